### rtl/tcp_handshake_fsm_macros.svh
// Assertion macros used by the connection state machine top level.
`ifndef TCP_HANDSHAKE_FSM_MACROS_SVH
`define TCP_HANDSHAKE_FSM_MACROS_SVH

// Same-cycle implication, ignored while reset is low.
`define TCPHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is low.
`define TCPHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tcphs_pkg.sv
// ----------------------------------------------------------------------------
// tcphs_pkg
// Event and segment codes, widths and the bundles passed between the
// input stage, the connection engine and the top level.
// ----------------------------------------------------------------------------
package tcphs_pkg;

    localparam int SEQ_W     = 32;
    localparam int ACT_W     = 4;
    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 3;
    localparam int CNT_OUT_W = 16;

    localparam logic [SEQ_W-1:0] ISN_RESET = 32'd100;

    // event codes
    localparam logic [ACT_W-1:0] EV_CONNECT = 4'd0;
    localparam logic [ACT_W-1:0] EV_LISTEN  = 4'd1;
    localparam logic [ACT_W-1:0] EV_CLOSE   = 4'd2;
    localparam logic [ACT_W-1:0] EV_RST     = 4'd3;
    localparam logic [ACT_W-1:0] EV_SYN     = 4'd4;
    localparam logic [ACT_W-1:0] EV_SYN_ACK = 4'd5;
    localparam logic [ACT_W-1:0] EV_ACK     = 4'd6;
    localparam logic [ACT_W-1:0] EV_FIN     = 4'd7;

    // outgoing segment kinds
    localparam logic [KIND_W-1:0] K_SYN     = 2'd0;
    localparam logic [KIND_W-1:0] K_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] K_SYN_ACK = 2'd2;
    localparam logic [KIND_W-1:0] K_RST     = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SEQ_W-1:0] seg_seq;
        logic [SEQ_W-1:0] seg_ack;
    } t_event;

    typedef struct packed {
        logic fire;    // advance the held request into the result register
        logic cfg_we;  // load initial and next send sequence number
    } t_ctl;

    typedef struct packed {
        logic                 ok;
        logic                 send_valid;
        logic [KIND_W-1:0]    send_kind;
        logic [SEQ_W-1:0]     send_seq;
        logic [SEQ_W-1:0]     send_ack;
        logic [PHASE_W-1:0]   conn_state;
        logic [CNT_OUT_W-1:0] dup_ack_count;
        logic [CNT_OUT_W-1:0] failed_count;
    } t_result;

endpackage

### rtl/tcphs_in_stage.sv
// ----------------------------------------------------------------------------
// tcphs_in_stage
// Input register: captures one request and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module tcphs_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tcphs_pkg::t_event i_event,
    input  logic              i_fire,
    output logic              o_stall,
    output logic              o_valid,
    output tcphs_pkg::t_event o_event
);
    import tcphs_pkg::*;

    logic   r_valid;
    t_event r_event;
    logic   take;

    // free when empty or when the held request moves on this cycle
    assign o_stall = r_valid && !i_fire;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_event <= i_event;
            end else if (i_fire) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;

endmodule

### rtl/tcphs_engine.sv
// ----------------------------------------------------------------------------
// tcphs_engine
// Connection state machine: phase, send sequence, counters and result register.
// ----------------------------------------------------------------------------
module tcphs_engine #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcphs_pkg::t_ctl               i_ctl,
    input  logic [tcphs_pkg::SEQ_W-1:0]   i_cfg_data,
    input  tcphs_pkg::t_event             i_event,
    output tcphs_pkg::t_result            o_result
);
    import tcphs_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        ST_CLOSED   = 3'd0,
        ST_LISTEN   = 3'd1,
        ST_SYN_RCVD = 3'd2,
        ST_SYN_SENT = 3'd3,
        ST_ESTAB    = 3'd4
    } t_phase;

    localparam int OUT_W = (COUNT_WIDTH < CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

    t_phase                   r_state,  n_state;
    logic [SEQ_W-1:0]         r_isn;
    logic [SEQ_W-1:0]         r_nss,    n_nss;
    logic [COUNT_WIDTH-1:0]   r_dup,    n_dup;
    logic [COUNT_WIDTH-1:0]   r_fail,   n_fail;
    logic                     r_ok,     n_ok;
    logic                     r_sv,     n_sv;
    logic [KIND_W-1:0]        r_kind,   n_kind;
    logic [SEQ_W-1:0]         r_seq,    n_seq;
    logic [SEQ_W-1:0]         r_ack,    n_ack;

    logic [SEQ_W-1:0]         seg_seq_p1;
    logic [SEQ_W-1:0]         nss_p1;
    logic [SEQ_W-1:0]         nss_m1;
    logic                     ack_match;
    logic [COUNT_WIDTH-1:0]   dup_inc;
    logic [COUNT_WIDTH-1:0]   fail_inc;

    assign seg_seq_p1 = i_event.seg_seq + 1'b1;
    assign nss_p1     = r_nss + 1'b1;
    assign nss_m1     = r_nss - 1'b1;
    assign ack_match  = (i_event.seg_ack == r_nss);
    assign dup_inc    = (&r_dup)  ? r_dup  : r_dup  + 1'b1;
    assign fail_inc   = (&r_fail) ? r_fail : r_fail + 1'b1;

    always_comb begin
        n_state = r_state;
        n_nss   = r_nss;
        n_dup   = r_dup;
        n_fail  = r_fail;
        n_ok    = 1'b1;
        n_sv    = 1'b0;
        n_kind  = K_SYN;
        n_seq   = '0;
        n_ack   = '0;

        if (i_event.action > EV_FIN) begin
            n_ok = 1'b0;
        end else begin
            case (r_state)
                ST_CLOSED: begin
                    if (i_event.action == EV_LISTEN) begin
                        n_state = ST_LISTEN;
                    end else if (i_event.action == EV_CONNECT) begin
                        n_sv    = 1'b1;
                        n_kind  = K_SYN;
                        n_seq   = r_nss;
                        n_nss   = nss_p1;
                        n_state = ST_SYN_SENT;
                    end else begin
                        n_sv   = 1'b1;
                        n_kind = K_RST;
                    end
                end
                ST_LISTEN: begin
                    if (i_event.action == EV_SYN) begin
                        n_sv    = 1'b1;
                        n_kind  = K_SYN_ACK;
                        n_seq   = r_nss;
                        n_ack   = seg_seq_p1;
                        n_nss   = nss_p1;
                        n_state = ST_SYN_RCVD;
                    end else begin
                        n_sv   = 1'b1;
                        n_kind = K_RST;
                    end
                end
                ST_SYN_RCVD: begin
                    if (i_event.action == EV_ACK) begin
                        if (!ack_match) begin
                            n_dup = dup_inc;
                        end else begin
                            n_dup   = '0;
                            n_state = ST_ESTAB;
                        end
                    end else if (i_event.action inside {EV_RST, EV_CLOSE}) begin
                        if (i_event.action == EV_RST) begin
                            n_fail = fail_inc;
                        end
                        n_nss   = r_isn;
                        n_dup   = '0;
                        n_state = ST_CLOSED;
                    end else begin
                        n_sv   = 1'b1;
                        n_kind = K_RST;
                    end
                end
                ST_SYN_SENT: begin
                    if (i_event.action == EV_SYN) begin
                        // simultaneous open: reuse the SYN's sequence number
                        n_sv    = 1'b1;
                        n_kind  = K_SYN_ACK;
                        n_seq   = nss_m1;
                        n_ack   = seg_seq_p1;
                        n_state = ST_SYN_RCVD;
                    end else if (i_event.action == EV_SYN_ACK) begin
                        n_sv = 1'b1;
                        if (!ack_match) begin
                            n_kind  = K_RST;
                            n_nss   = r_isn;
                            n_dup   = '0;
                            n_state = ST_CLOSED;
                        end else begin
                            n_kind  = K_ACK;
                            n_seq   = r_nss;
                            n_ack   = seg_seq_p1;
                            n_state = ST_ESTAB;
                        end
                    end else if (i_event.action == EV_RST) begin
                        n_fail  = fail_inc;
                        n_nss   = r_isn;
                        n_dup   = '0;
                        n_state = ST_CLOSED;
                    end
                end
                ST_ESTAB: begin
                    if (i_event.action == EV_ACK) begin
                        n_dup = ack_match ? '0 : dup_inc;
                    end else if (i_event.action inside {EV_FIN, EV_CLOSE}) begin
                        n_nss   = r_isn;
                        n_dup   = '0;
                        n_state = ST_CLOSED;
                    end else begin
                        n_ok = 1'b0;
                    end
                end
                default: begin
                    n_state = ST_CLOSED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLOSED;
            r_isn   <= ISN_RESET;
            r_nss   <= ISN_RESET;
            r_dup   <= '0;
            r_fail  <= '0;
        end else begin
            if (i_ctl.fire) begin
                r_state <= n_state;
                r_nss   <= n_nss;
                r_dup   <= n_dup;
                r_fail  <= n_fail;
                r_ok    <= n_ok;
                r_sv    <= n_sv;
                r_kind  <= n_kind;
                r_seq   <= n_seq;
                r_ack   <= n_ack;
            end
            if (i_ctl.cfg_we) begin
                r_isn <= i_cfg_data;
                r_nss <= i_cfg_data;
            end
        end
    end

    // phase and counters only move on a fire, so they stay with the held result
    assign o_result.ok            = r_ok;
    assign o_result.send_valid    = r_sv;
    assign o_result.send_kind     = r_kind;
    assign o_result.send_seq      = r_seq;
    assign o_result.send_ack      = r_ack;
    assign o_result.conn_state    = r_state;
    assign o_result.dup_ack_count = CNT_OUT_W'(r_dup[OUT_W-1:0]);
    assign o_result.failed_count  = CNT_OUT_W'(r_fail[OUT_W-1:0]);

endmodule

### rtl/tcp_handshake_fsm.sv
// Simplified TCP connection state machine (closed, listen, syn received,
// syn sent, established). Each request on the input channel is one event:
// i_action with the received segment's i_seg_seq and i_seg_ack. Each
// request gives exactly one result on the output channel: ok flag, an
// optional SYN / ACK / SYN_ACK / RST segment, the phase after the event
// and the duplicate-ACK and failed-attempt counters (saturating).
// Both channels use valid/stall: a transfer happens on a rising edge with
// valid high and stall low.
// A request accepted into the input register passes through the engine
// into the result register, from which it is presented. Throughput is one
// request per cycle while the receiver does not stall, set by the single
// engine pass between the input register and the result register.
// When the receiver stalls, the result holds; the input register still
// takes one further request, after which o_in_stall is raised.
// Reset (synchronous, active low) returns to closed, zero counters and an
// initial sequence of 100. A write on i_cfg_we loads the initial sequence
// and the next send sequence; write only while the block is idle.
// ----------------------------------------------------------------------------
// tcp_handshake_fsm
// Top level: input stage, connection engine and output handshake.
// ----------------------------------------------------------------------------
module tcp_handshake_fsm #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_action,
    input  logic [31:0] i_seg_seq,
    input  logic [31:0] i_seg_ack,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic        o_send_valid,
    output logic [1:0]  o_send_kind,
    output logic [31:0] o_send_seq,
    output logic [31:0] o_send_ack,
    output logic [2:0]  o_conn_state,
    output logic [15:0] o_dup_ack_count,
    output logic [15:0] o_failed_count
);
    import tcphs_pkg::*;

    t_event  in_event;
    t_event  held_event;
    logic    held_valid;
    t_ctl    ctl;
    t_result result;
    logic    out_free;
    logic    r_out_valid;

    assign in_event.action  = i_action;
    assign in_event.seg_seq = i_seg_seq;
    assign in_event.seg_ack = i_seg_ack;

    // result register is free when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ctl.fire   = held_valid && out_free;
    assign ctl.cfg_we = i_cfg_we;

    tcphs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_event (in_event),
        .i_fire  (ctl.fire),
        .o_stall (o_in_stall),
        .o_valid (held_valid),
        .o_event (held_event)
    );

    tcphs_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cfg_data (i_cfg_data),
        .i_event    (held_event),
        .o_result   (result)
    );

    // advance on fire, drop once taken, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = result.ok;
    assign o_send_valid    = result.send_valid;
    assign o_send_kind     = result.send_kind;
    assign o_send_seq      = result.send_seq;
    assign o_send_ack      = result.send_ack;
    assign o_conn_state    = result.conn_state;
    assign o_dup_ack_count = result.dup_ack_count;
    assign o_failed_count  = result.failed_count;

`include "tcp_handshake_fsm_macros.svh"

    `TCPHS_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, ctl.fire, o_out_valid, "fired request produced no result")
    `TCPHS_ASSERT_NEXT(a_stalled_phase_held, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_conn_state) && $stable(o_dup_ack_count), "phase or counter moved under a stalled result")
    `TCPHS_ASSERT_NOW(a_not_ok_sends_nothing, i_clk, i_rst_n, o_out_valid && !o_ok, !o_send_valid, "segment sent for a rejected event")
    `TCPHS_ASSERT_NOW(a_rst_carries_zeros, i_clk, i_rst_n, o_out_valid && o_send_valid && o_send_kind == K_RST, o_send_seq == '0 && o_send_ack == '0, "RST segment with non-zero seq or ack")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP connection state machine testbench
// Drives connection events (socket calls and received segments) through the
// valid/stall request channel, predicts every result with a local model of
// the five-state handshake, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
    import tcphs_pkg::*;

    // Phase codes as reported on o_conn_state
    localparam logic [2:0] PH_CLOSED   = 3'd0;
    localparam logic [2:0] PH_LISTEN   = 3'd1;
    localparam logic [2:0] PH_SYN_RCVD = 3'd2;
    localparam logic [2:0] PH_SYN_SENT = 3'd3;
    localparam logic [2:0] PH_ESTAB    = 3'd4;

    // Event codes beyond the supported set
    localparam logic [3:0] EV_UNSUPPORTED = 4'd8;
    localparam logic [3:0] EV_TOP_CODE    = 4'd15;

    localparam logic [15:0] COUNT_CEILING  = 16'hFFFF;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          CYCLE_LIMIT    = 1_500_000;
    localparam int          REPORT_LIMIT   = 10;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [3:0]  action    = '0;
    logic [31:0] seg_seq   = '0;
    logic [31:0] seg_ack   = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic        ok;
    logic        send_valid;
    logic [1:0]  send_kind;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [2:0]  conn_state;
    logic [15:0] dup_ack_count;
    logic [15:0] failed_count;

    always #6 clk = ~clk;

    tcp_handshake_fsm DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (action),
        .i_seg_seq       (seg_seq),
        .i_seg_ack       (seg_ack),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_ok            (ok),
        .o_send_valid    (send_valid),
        .o_send_kind     (send_kind),
        .o_send_seq      (send_seq),
        .o_send_ack      (send_ack),
        .o_conn_state    (conn_state),
        .o_dup_ack_count (dup_ack_count),
        .o_failed_count  (failed_count)
    );

    // ------------------------------------------------------------------
    // Connection model: its own copy of the register and the state
    // ------------------------------------------------------------------
    logic [31:0] isn_reg    = ISN_RESET;
    logic [2:0]  cur_phase  = PH_CLOSED;
    logic [31:0] snd_nxt    = ISN_RESET;
    logic [15:0] dupack_cnt = '0;
    logic [15:0] fail_cnt   = '0;

    t_result     replies_due[$];   // predicted results, oldest first
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;

    // Pacing controls shared by the test tasks and the pacing process
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    int unsigned holdoff_ticket = 0;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == COUNT_CEILING) ? v : v + 16'd1;
    endfunction

    // Drop the connection: reload the send sequence, clear duplicate ACKs
    function automatic void close_connection();
        snd_nxt    = isn_reg;
        dupack_cnt = '0;
        cur_phase  = PH_CLOSED;
    endfunction

    // Advance the model by one event and return the result it should give
    function automatic t_result apply_event(input logic [3:0] act,
                                            input logic [31:0] sseq,
                                            input logic [31:0] sack);
        t_result r;
        r    = '0;
        r.ok = 1'b1;
        if (act > EV_FIN) begin
            // unsupported codes change nothing, in every phase
            r.ok = 1'b0;
        end else begin
            case (cur_phase)
                PH_CLOSED: begin
                    if (act == EV_LISTEN) begin
                        cur_phase = PH_LISTEN;
                    end else if (act == EV_CONNECT) begin
                        r.send_valid = 1'b1;
                        r.send_kind  = K_SYN;
                        r.send_seq   = snd_nxt;
                        snd_nxt      = snd_nxt + 32'd1;
                        cur_phase    = PH_SYN_SENT;
                    end else begin
                        r.send_valid = 1'b1;
                        r.send_kind  = K_RST;
                    end
                end
                PH_LISTEN: begin
                    if (act == EV_SYN) begin
                        r.send_valid = 1'b1;
                        r.send_kind  = K_SYN_ACK;
                        r.send_seq   = snd_nxt;
                        r.send_ack   = sseq + 32'd1;
                        snd_nxt      = snd_nxt + 32'd1;
                        cur_phase    = PH_SYN_RCVD;
                    end else begin
                        r.send_valid = 1'b1;
                        r.send_kind  = K_RST;
                    end
                end
                PH_SYN_RCVD: begin
                    if (act == EV_ACK) begin
                        if (sack != snd_nxt) begin
                            dupack_cnt = sat_inc(dupack_cnt);
                        end else begin
                            dupack_cnt = '0;
                            cur_phase  = PH_ESTAB;
                        end
                    end else if (act == EV_RST) begin
                        fail_cnt = sat_inc(fail_cnt);
                        close_connection();
                    end else if (act == EV_CLOSE) begin
                        close_connection();
                    end else begin
                        r.send_valid = 1'b1;
                        r.send_kind  = K_RST;
                    end
                end
                PH_SYN_SENT: begin
                    if (act == EV_SYN) begin
                        // simultaneous open: reuse the sequence of our SYN
                        r.send_valid = 1'b1;
                        r.send_kind  = K_SYN_ACK;
                        r.send_seq   = snd_nxt - 32'd1;
                        r.send_ack   = sseq + 32'd1;
                        cur_phase    = PH_SYN_RCVD;
                    end else if (act == EV_SYN_ACK) begin
                        if (sack != snd_nxt) begin
                            r.send_valid = 1'b1;
                            r.send_kind  = K_RST;
                            close_connection();
                        end else begin
                            r.send_valid = 1'b1;
                            r.send_kind  = K_ACK;
                            r.send_seq   = snd_nxt;
                            r.send_ack   = sseq + 32'd1;
                            cur_phase    = PH_ESTAB;
                        end
                    end else if (act == EV_RST) begin
                        fail_cnt = sat_inc(fail_cnt);
                        close_connection();
                    end
                    // anything else is ignored while waiting for the peer
                end
                default: begin
                    if (act == EV_ACK) begin
                        if (sack != snd_nxt) begin
                            dupack_cnt = sat_inc(dupack_cnt);
                        end else begin
                            dupack_cnt = '0;
                        end
                    end else if (act inside {EV_FIN, EV_CLOSE}) begin
                        close_connection();
                    end else begin
                        r.ok = 1'b0;
                    end
                end
            endcase
        end
        r.conn_state    = cur_phase;
        r.dup_ack_count = dupack_cnt;
        r.failed_count  = fail_cnt;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until taken, then predict its result.
    // Valid stays high into the next request unless a gap is drawn.
    task automatic send_event(input logic [3:0] act, input logic [31:0] sseq,
                              input logic [31:0] sack);
        int unsigned gap;
        in_valid <= 1'b1;
        action   <= act;
        seg_seq  <= sseq;
        seg_ack  <= sack;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        replies_due.push_back(apply_event(act, sseq, sack));
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Draw an event that suits the current phase, with some noise mixed in
    task automatic send_random_event();
        logic [3:0]  act;
        logic [31:0] sseq;
        logic [31:0] sack;
        logic [31:0] bad_ack;
        int unsigned roll;
        sseq    = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom();
        sack    = $urandom();
        bad_ack = snd_nxt ^ ($urandom() | 32'd1);
        roll    = $urandom_range(0, 99);
        if (roll < 12) begin
            act = 4'($urandom_range(0, 15));
        end else begin
            case (cur_phase)
                PH_CLOSED: begin
                    if (roll < 55)      act = EV_CONNECT;
                    else if (roll < 90) act = EV_LISTEN;
                    else                act = 4'($urandom_range(EV_CLOSE, EV_FIN));
                end
                PH_LISTEN: begin
                    if (roll < 85) act = EV_SYN;
                    else           act = 4'($urandom_range(EV_CONNECT, EV_FIN));
                end
                PH_SYN_SENT: begin
                    if (roll < 60) begin
                        act  = EV_SYN_ACK;
                        sack = snd_nxt;
                    end else if (roll < 72) begin
                        act  = EV_SYN_ACK;
                        sack = bad_ack;
                    end else if (roll < 84) begin
                        act = EV_SYN;
                    end else if (roll < 92) begin
                        act = EV_RST;
                    end else begin
                        act = 4'($urandom_range(EV_CONNECT, EV_FIN));
                    end
                end
                PH_SYN_RCVD: begin
                    if (roll < 60) begin
                        act  = EV_ACK;
                        sack = snd_nxt;
                    end else if (roll < 75) begin
                        act  = EV_ACK;
                        sack = bad_ack;
                    end else if (roll < 83) begin
                        act = EV_RST;
                    end else if (roll < 90) begin
                        act = EV_CLOSE;
                    end else begin
                        act = 4'($urandom_range(EV_CONNECT, EV_FIN));
                    end
                end
                default: begin
                    if (roll < 50) begin
                        act  = EV_ACK;
                        sack = snd_nxt;
                    end else if (roll < 70) begin
                        act  = EV_ACK;
                        sack = bad_ack;
                    end else if (roll < 82) begin
                        act = EV_FIN;
                    end else if (roll < 88) begin
                        act = EV_CLOSE;
                    end else begin
                        act = 4'($urandom_range(EV_CONNECT, EV_UNSUPPORTED));
                    end
                end
            endcase
        end
        send_event(act, sseq, sack);
    endtask

    // Drop valid and let every predicted result come home
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Load the initial sequence; only ever done with the block idle
    task automatic write_isn(input logic [31:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        isn_reg = value;
        snd_nxt = value;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pacing in one process, checking in another
    // ------------------------------------------------------------------

    // Receiver pacing. A new holdoff ticket holds the result channel off
    // for a long, counted stretch, regardless of the idling switch.
    always @(posedge clk) begin : rx_pacing
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned ticket_seen;
        if (ticket_seen != holdoff_ticket) begin
            ticket_seen = holdoff_ticket;
            hold_left   = HOLDOFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (!rx_idle) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("result %0d: %s expected %h, got %h",
                         results_seen, what, want, got);
            end
        end
    endtask

    // Take each result as it is accepted and compare it with the oldest
    // prediction
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d: arrived with no request outstanding",
                             results_seen);
                end
            end else begin
                want = replies_due.pop_front();
                check_field("ok",         32'(want.ok),         32'(ok));
                check_field("send_valid", 32'(want.send_valid), 32'(send_valid));
                check_field("send_kind",  32'(want.send_kind),  32'(send_kind));
                check_field("send_seq",   want.send_seq,        send_seq);
                check_field("send_ack",   want.send_ack,        send_ack);
                check_field("conn_state", 32'(want.conn_state), 32'(conn_state));
                check_field("dup_ack_count", 32'(want.dup_ack_count),
                            32'(dup_ack_count));
                check_field("failed_count", 32'(want.failed_count),
                            32'(failed_count));
            end
        end
    end

    // Hard stop if the handshakes hang
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Passive open with the initial sequence from reset, plus the
    // unexpected and unsupported events met along the way
    task automatic test_passive_open();
        send_event(EV_SYN, 32'h0, 32'h0);                  // RST while closed
        send_event(EV_LISTEN, 32'h0, 32'h0);
        send_event(EV_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // RST while listening
        send_event(EV_SYN, 32'hFFFF_FFFF, 32'h0);          // SYN_ACK, ack wraps to 0
        send_event(EV_ACK, 32'h0, 32'hFFFF_FFFF);          // wrong ack, count up
        send_event(EV_SYN_ACK, 32'h0, 32'h0);              // RST in syn received
        send_event(EV_ACK, 32'h0, snd_nxt);                // established
        send_event(EV_ACK, 32'h0, 32'h0);                  // duplicate
        send_event(EV_SYN, 32'h0, 32'h0);                  // unexpected: ok low
        send_event(EV_UNSUPPORTED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(EV_TOP_CODE, 32'h0, 32'h0);
        send_event(EV_FIN, 32'h0, 32'h0);
    endtask

    // Active open: ignored event, bad and good SYN_ACK, peer reset
    task automatic test_active_open();
        send_event(EV_CONNECT, 32'h0, 32'h0);
        send_event(EV_FIN, 32'h0, 32'h0);                  // ignored in syn sent
        send_event(EV_SYN_ACK, 32'h0, snd_nxt - 32'd1);    // wrong ack: RST, closed
        send_event(EV_CONNECT, 32'h0, 32'h0);
        send_event(EV_SYN_ACK, 32'hFFFF_FFFF, snd_nxt);    // ACK, established
        send_event(EV_CLOSE, 32'h0, 32'h0);
        send_event(EV_CONNECT, 32'h0, 32'h0);
        send_event(EV_RST, 32'h0, 32'h0);                  // failed attempt
    endtask

    // Simultaneous open, then leave syn received by reset and by close
    task automatic test_simultaneous_open();
        send_event(EV_CONNECT, 32'h0, 32'h0);
        send_event(EV_SYN, 32'd5, 32'h0);
        send_event(EV_RST, 32'h0, 32'h0);
        send_event(EV_CONNECT, 32'h0, 32'h0);
        send_event(EV_SYN, 32'h8000_0000, 32'h0);
        send_event(EV_CLOSE, 32'h0, 32'h0);
    endtask

    // Send sequence wrapping from the top of the range back to zero
    task automatic test_sequence_wrap();
        write_isn(32'hFFFF_FFFF);
        send_event(EV_CONNECT, 32'h0, 32'h0);
        send_event(EV_SYN_ACK, 32'h1234_5678, 32'h0);
        send_event(EV_CLOSE, 32'h0, 32'h0);
    endtask

    // Random traffic over several initial sequences and pacing mixes
    task automatic test_random_traffic();
        logic [31:0] isn;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       isn = 32'd0;
                1:       isn = 32'hFFFF_FFFF;
                2:       isn = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                3:       isn = ISN_RESET;
                default: isn = $urandom();
            endcase
            write_isn(isn);
            tx_idle = (p == 1 || p >= 3);
            rx_idle = (p >= 2);
            repeat (130) send_random_event();
        end
        wait_idle();
    endtask

    // Hold the result channel off for a long stretch while requests keep
    // coming, so the block fills and stalls its input
    task automatic test_backpressure();
        write_isn($urandom());
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        holdoff_ticket++;
        repeat (40) send_random_event();
        wait_idle();
    endtask

    // Walk back to closed through random traffic
    task automatic return_to_closed();
        while (cur_phase != PH_CLOSED) send_random_event();
    endtask

    // Run up the duplicate-ACK counter with wrong acks, then clear it
    task automatic test_dup_ack_run();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        return_to_closed();
        send_event(EV_LISTEN, 32'h0, 32'h0);
        send_event(EV_SYN, $urandom(), 32'h0);
        send_event(EV_ACK, 32'h0, snd_nxt);
        repeat (40) begin
            send_event(EV_ACK, $urandom(), snd_nxt ^ ($urandom() | 32'd1));
        end
        send_event(EV_ACK, 32'h0, snd_nxt);
        send_event(EV_FIN, 32'h0, 32'h0);
        wait_idle();
    endtask

    // Failed attempts only ever count up; reset a run of active opens
    task automatic test_failed_attempts();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        return_to_closed();
        repeat (20) begin
            send_event(EV_CONNECT, 32'h0, 32'h0);
            send_event(EV_RST, $urandom(), $urandom());
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_passive_open();
        test_active_open();
        test_simultaneous_open();
        test_sequence_wrap();
        test_random_traffic();
        test_backpressure();
        test_dup_ack_run();
        test_failed_attempts();
        // Wait for any stray result to show up
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
